/* sv/tts_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the thermal trip throttle selector.
// Used by tts_ctrl, tts_datapath and the top level; depends on nothing.
package tts_pkg;

  // Field widths
  localparam int TEMP_W = 18;
  localparam int KHZ_W  = 22;
  localparam int ZSEL_W = 3;
  localparam int ZCNT_W = 4;
  localparam int FUNC_W = 2;
  localparam int CLU_W  = 2;

  // Packed stream widths
  localparam int IN_W  = 152;
  localparam int OUT_W = 72;

  // Default sizes
  localparam int WINDOW_LEN_DEF = 10;
  localparam int MAX_ZONES_DEF  = 8;

  // Cluster codes; anything else selects the prime cluster
  localparam logic [CLU_W-1:0] CL_LITTLE = 2'd0;
  localparam logic [CLU_W-1:0] CL_MID    = 2'd1;

  // Request kinds carried on tuser
  typedef enum logic [FUNC_W-1:0] {
    FN_SAMPLE  = 2'd0,
    FN_ZONE_WR = 2'd1,
    FN_ENABLE  = 2'd2,
    FN_QUERY   = 2'd3
  } func_t;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SAMPLE,
    ST_DIV_INIT,
    ST_DIV,
    ST_DIV_END,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_SELECT,
    ST_QUERY,
    ST_DONE
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic capture;
    logic exec;
    logic sample_upd;
    logic div_init;
    logic div_step;
    logic div_end;
    logic scan_cmp;
    logic select;
    logic query;
    logic load_out;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    func_t func;
    logic  enabled;
    logic  eval;
    logic  lim_zero;
    logic  trip_hit;
    logic  idx_zero;
    logic  out_free;
  } stat_t;

endpackage

/* sv/thermal_trip_throttle_selector.sv */
`timescale 1ns / 1ps
// Top level of the thermal trip throttle selector.
// Depends on tts_pkg, tts_ctrl and tts_datapath.
//
//   channel   direction  handshake            payload
//   s_*       in         s_tvalid / s_tready  s_tuser func, s_tdata request fields
//   m_*       out        m_tvalid / m_tready  m_tdata result fields
//   cfg_*     in         cfg_valid/cfg_ready  cfg_data zone_count
//
// One request at a time. Zone writes, enable and disabled samples go from decode
// straight to done; a query passes through the query state, a warm-up sample
// through the sample state. An evaluated sample runs the reciprocal divide (init,
// step, end), then scans zones downward, a trip table read and compare per zone.
// Reset is synchronous and holds both ready outputs low; zone tables hold
// garbage until written.
// A stalled result sits in the output register; the next request is taken
// meanwhile and waits at its end only if the register is still full.
module thermal_trip_throttle_selector
  import tts_pkg::*;
#(
  parameter int WINDOW_LEN = WINDOW_LEN_DEF,
  parameter int MAX_ZONES  = MAX_ZONES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  // func[1:0]
  input  logic [FUNC_W-1:0] s_tuser,
  // temp_milli_c[17:0], zone_sel[20:18], trip_milli_c[38:21], little_cap_khz[60:39],
  // mid_cap_khz[82:61], top_cap_khz[104:83], enable_bit[105], cluster[107:106],
  // user_max_khz[129:108], policy_min_khz[151:130]
  input  logic [IN_W-1:0]   s_tdata,
  output logic              m_tvalid,
  input  logic              m_tready,
  // avg_milli_c[17:0], history_ready[18], zone_active[19], zone_now[22:20],
  // zone_changed[23], cap_max_khz[45:24], cap_min_khz[67:46], zero[71:68]
  output logic [OUT_W-1:0]  m_tdata,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [ZCNT_W-1:0] cfg_data
);

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = !rst;

  tts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tts_datapath #(
    .WINDOW_LEN (WINDOW_LEN),
    .MAX_ZONES  (MAX_ZONES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .s_tuser   (s_tuser),
    .s_tdata   (s_tdata),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .m_tready  (m_tready),
    .cmd       (cmd),
    .stat      (stat),
    .m_tvalid  (m_tvalid),
    .m_tdata   (m_tdata)
  );

endmodule

/* sv/tts_ctrl.sv */
`timescale 1ns / 1ps
// Sequencing state machine of the thermal trip throttle selector.
// Depends on tts_pkg; drives the command struct of tts_datapath.
module tts_ctrl
  import tts_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  s_tvalid,
  output logic  s_tready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_DECODE;
      end
      ST_DECODE: begin
        unique case (stat.func)
          FN_SAMPLE:  state_next = stat.enabled ? ST_SAMPLE : ST_DONE;
          FN_ZONE_WR: state_next = ST_DONE;
          FN_ENABLE:  state_next = ST_DONE;
          FN_QUERY:   state_next = ST_QUERY;
          default:    state_next = ST_DONE;
        endcase
      end
      ST_SAMPLE:   state_next = stat.eval ? ST_DIV_INIT : ST_DONE;
      ST_DIV_INIT: state_next = ST_DIV;
      ST_DIV:      state_next = ST_DIV_END;
      ST_DIV_END:  state_next = stat.lim_zero ? ST_SELECT : ST_SCAN_RD;
      ST_SCAN_RD:  state_next = ST_SCAN_CMP;
      ST_SCAN_CMP: begin
        state_next = (stat.trip_hit || stat.idx_zero) ? ST_SELECT : ST_SCAN_RD;
      end
      ST_SELECT:   state_next = ST_DONE;
      ST_QUERY:    state_next = ST_DONE;
      ST_DONE: begin
        if (stat.out_free) state_next = ST_IDLE;
      end
      default:     state_next = ST_IDLE;
    endcase
  end

  // Command outputs; no request is taken while reset is held
  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready    = !rst;
        cmd.capture = s_tvalid && !rst;
      end
      ST_DECODE:   cmd.exec       = 1'b1;
      ST_SAMPLE:   cmd.sample_upd = 1'b1;
      ST_DIV_INIT: cmd.div_init   = 1'b1;
      ST_DIV:      cmd.div_step   = 1'b1;
      ST_DIV_END:  cmd.div_end    = 1'b1;
      ST_SCAN_RD:  cmd            = '0;
      ST_SCAN_CMP: cmd.scan_cmp   = 1'b1;
      ST_SELECT:   cmd.select     = 1'b1;
      ST_QUERY:    cmd.query      = 1'b1;
      ST_DONE:     cmd.load_out   = stat.out_free;
      default:     cmd            = '0;
    endcase
  end

endmodule

/* sv/tts_datapath.sv */
`timescale 1ns / 1ps
// Datapath: sample window, running sum, divider, zone tables, output register.
// Depends on tts_pkg; steered by the command struct from tts_ctrl.
module tts_datapath
  import tts_pkg::*;
#(
  parameter int WINDOW_LEN = WINDOW_LEN_DEF,
  parameter int MAX_ZONES  = MAX_ZONES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [FUNC_W-1:0] s_tuser,
  input  logic [IN_W-1:0]   s_tdata,
  input  logic              cfg_valid,
  input  logic [ZCNT_W-1:0] cfg_data,
  input  logic              m_tready,
  input  cmd_t              cmd,
  output stat_t             stat,
  output logic              m_tvalid,
  output logic [OUT_W-1:0]  m_tdata
);

  localparam int WPW  = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int ZW   = (MAX_ZONES > 1) ? $clog2(MAX_ZONES) : 1;
  localparam int SW   = TEMP_W + $clog2(WINDOW_LEN);
  // floor(x * RECIP / 2^RSH) equals floor(x / WINDOW_LEN) for every x below 2^SW
  localparam int RSH  = SW + $clog2(WINDOW_LEN);
  localparam int RCW  = SW + 1;
  localparam int PW   = 2 * SW + 1;
  localparam logic [RCW-1:0] RECIP =
      RCW'(((64'd1 << RSH) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN));
  localparam logic [7:0]  MZ8     = 8'(MAX_ZONES);

  // Captured request
  func_t                    func_r;
  logic signed [TEMP_W-1:0] temp_r;
  logic [ZSEL_W-1:0]        zsel_r;
  logic signed [TEMP_W-1:0] trip_r;
  logic [KHZ_W-1:0]         lcap_r, mcap_r, tcap_r;
  logic                     en_bit_r;
  logic [CLU_W-1:0]         cluster_r;
  logic [KHZ_W-1:0]         umax_r, pmin_r;

  // Control state
  logic [ZCNT_W-1:0]        zone_count;
  logic                     enabled;
  logic                     warming;
  logic [WPW-1:0]           wpos;
  logic signed [SW-1:0]     sum;
  logic                     have_zone;
  logic [ZW-1:0]            cur_zone;

  // Window memory
  logic signed [TEMP_W-1:0] win [WINDOW_LEN];
  logic signed [TEMP_W-1:0] win_q;

  // Zone tables
  logic signed [TEMP_W-1:0] trip_mem [MAX_ZONES];
  logic [KHZ_W-1:0]         lcap_mem [MAX_ZONES];
  logic [KHZ_W-1:0]         mcap_mem [MAX_ZONES];
  logic [KHZ_W-1:0]         tcap_mem [MAX_ZONES];
  logic signed [TEMP_W-1:0] trip_q;
  logic [KHZ_W-1:0]         cap_q;

  // Divider and scan
  logic [SW-1:0]            dmag;
  logic                     dneg;
  logic [PW-1:0]            dprod;
  logic signed [TEMP_W-1:0] avg;
  logic [ZW-1:0]            sidx;
  logic                     hit;

  // Result fields
  logic signed [TEMP_W-1:0] res_avg;
  logic                     res_ready;
  logic                     res_changed;
  logic [KHZ_W-1:0]         res_cmax, res_cmin;

  // Combinational helpers
  logic                     wpos_last;
  logic                     zsel_ok;
  logic [7:0]               zc_ext, lim;
  logic [TEMP_W-1:0]        qmag;
  logic                     trip_ge;
  logic                     changed;
  logic                     use_tab;
  logic [KHZ_W-1:0]         cmax;
  logic [ZW+2:0]            zone_ext;

  assign wpos_last = (wpos == WPW'(WINDOW_LEN - 1));
  assign zsel_ok   = ({5'd0, zsel_r} < MZ8);
  assign zc_ext    = {4'd0, zone_count};
  assign lim       = (zc_ext > MZ8) ? MZ8 : zc_ext;
  assign qmag      = dprod[RSH +: TEMP_W];
  assign trip_ge   = (avg >= trip_q);
  assign changed   = (hit != have_zone) || (hit && (sidx != cur_zone));
  assign use_tab   = have_zone && enabled;
  assign cmax      = use_tab ? cap_q : umax_r;
  assign zone_ext  = {3'd0, cur_zone};

  // Status to controller
  always_comb begin
    stat          = '0;
    stat.func     = func_r;
    stat.enabled  = enabled;
    stat.eval     = !warming || wpos_last;
    stat.lim_zero = (lim == 8'd0);
    stat.trip_hit = trip_ge;
    stat.idx_zero = (sidx == '0);
    stat.out_free = !m_tvalid || m_tready;
  end

  // Request capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r    <= func_t'(s_tuser);
      temp_r    <= s_tdata[17:0];
      zsel_r    <= s_tdata[20:18];
      trip_r    <= s_tdata[38:21];
      lcap_r    <= s_tdata[60:39];
      mcap_r    <= s_tdata[82:61];
      tcap_r    <= s_tdata[104:83];
      en_bit_r  <= s_tdata[105];
      cluster_r <= s_tdata[107:106];
      umax_r    <= s_tdata[129:108];
      pmin_r    <= s_tdata[151:130];
    end
  end

  // Zone count register
  always_ff @(posedge clk) begin
    if (rst) begin
      zone_count <= ZCNT_W'(1);
    end else if (cfg_valid) begin
      zone_count <= cfg_data;
    end
  end

  // Enable, warm-up tracking and running window sum
  always_ff @(posedge clk) begin
    if (rst) begin
      enabled <= 1'b1;
      warming <= 1'b1;
      wpos    <= '0;
      sum     <= '0;
    end else if (cmd.exec && func_r == FN_ENABLE) begin
      enabled <= en_bit_r;
      if (en_bit_r) begin
        warming <= 1'b1;
        wpos    <= '0;
        sum     <= '0;
      end
    end else if (cmd.sample_upd) begin
      // old slot drops out once the window has been filled
      sum     <= sum + SW'(temp_r) - (warming ? SW'(0) : SW'(win_q));
      wpos    <= wpos_last ? '0 : wpos + WPW'(1);
      if (wpos_last) warming <= 1'b0;
    end
  end

  // Window memory: read the slot about to be overwritten
  always_ff @(posedge clk) begin
    if (cmd.sample_upd) win[wpos] <= temp_r;
    win_q <= win[wpos];
  end

  // Zone tables: write on zone request, read trip at scan index, cap at current zone
  always_ff @(posedge clk) begin
    if (cmd.exec && func_r == FN_ZONE_WR && zsel_ok) begin
      trip_mem[ZW'(zsel_r)] <= trip_r;
      lcap_mem[ZW'(zsel_r)] <= lcap_r;
      mcap_mem[ZW'(zsel_r)] <= mcap_r;
      tcap_mem[ZW'(zsel_r)] <= tcap_r;
    end
    trip_q <= trip_mem[sidx];
    case (cluster_r)
      CL_LITTLE: cap_q <= lcap_mem[cur_zone];
      CL_MID:    cap_q <= mcap_mem[cur_zone];
      default:   cap_q <= tcap_mem[cur_zone];
    endcase
  end

  // Divide the sum magnitude by the window length: take the magnitude, then
  // multiply by the scaled reciprocal; the sign goes back on at div_end
  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      dneg <= sum[SW-1];
      dmag <= sum[SW-1] ? $unsigned(-sum) : $unsigned(sum);
    end
    if (cmd.div_step) begin
      dprod <= PW'(dmag) * PW'(RECIP);
    end
  end

  // Average and downward zone scan
  always_ff @(posedge clk) begin
    if (cmd.div_end) begin
      avg  <= dneg ? (~qmag + TEMP_W'(1)) : qmag;
      sidx <= ZW'(lim - 8'd1);
      hit  <= 1'b0;
    end else if (cmd.scan_cmp) begin
      if (trip_ge) begin
        hit <= 1'b1;
      end else if (sidx != '0) begin
        sidx <= sidx - ZW'(1);
      end
    end
  end

  // Selected zone
  always_ff @(posedge clk) begin
    if (rst) begin
      have_zone <= 1'b0;
      cur_zone  <= '0;
    end else if (cmd.select) begin
      have_zone <= hit;
      cur_zone  <= hit ? sidx : '0;
    end
  end

  // Result fields of the current request
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      res_avg     <= '0;
      res_ready   <= 1'b0;
      res_changed <= 1'b0;
      res_cmax    <= '0;
      res_cmin    <= '0;
    end else if (cmd.select) begin
      res_avg     <= avg;
      res_ready   <= 1'b1;
      res_changed <= changed;
    end else if (cmd.query) begin
      res_cmax    <= cmax;
      res_cmin    <= (pmin_r > cmax) ? cmax : pmin_r;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      m_tdata <= {4'd0, res_cmin, res_cmax, res_changed, zone_ext[2:0], have_zone,
                  res_ready, res_avg};
    end
  end

endmodule
